[sv/gpx_pkg.sv]
// Package for the I2C GPIO expander register block.
// Holds word types, register/kind/status codes and the active-pin mask helper.
// No dependencies.
`timescale 1ns / 1ps

package gpx_pkg;

  localparam int PIN_COUNT = 16;  // 8..16
  localparam int CFG_AW    = 3;

  localparam logic [15:0] FULL_MASK = 16'((32'd1 << PIN_COUNT) - 32'd1);
  localparam logic [15:0] LOW_MASK  = 16'h00FF;

  // input item kinds
  localparam logic [2:0] KIND_START = 3'd0;
  localparam logic [2:0] KIND_OTHER = 3'd1;
  localparam logic [2:0] KIND_WRITE = 3'd2;
  localparam logic [2:0] KIND_READ  = 3'd3;
  localparam logic [2:0] KIND_PINS  = 3'd4;

  // register select codes
  localparam logic [7:0] REG_INPUT     = 8'd0;
  localparam logic [7:0] REG_OUTPUT    = 8'd1;
  localparam logic [7:0] REG_POLARITY  = 8'd2;
  localparam logic [7:0] REG_DIRECTION = 8'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNSUP = 2'd1;
  localparam logic [1:0] ST_RO    = 2'd2;

  // configuration register indexes
  localparam logic CFG_IDX_MODE = 1'b0;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] pin_levels;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] pin_outputs;
    logic [1:0]  status;
  } out_word_t;

  function automatic logic [15:0] active_mask(input logic sixteen_bit_mode);
    return sixteen_bit_mode ? FULL_MASK : LOW_MASK;
  endfunction

endpackage

[sv/i2c_gpio_expander_registers.sv]
// Top level of the I2C GPIO expander register block.
// Handshake, two-entry result buffer and APB-style mode register; uses gpx_core.
// Depends on gpx_pkg.
//
// Usage:
//   The input channel (in_valid/in_stall/in_data) carries one word per bus
//   event or pin-level sample. Each accepted word yields exactly one result
//   word on the output channel (out_valid/out_stall/out_data), in order.
//   Each result word is formed combinationally and registered at the edge that
//   accepts its input word. Throughput is one word per cycle while in_stall is
//   low; the register updates are a single level of bitwise logic between the
//   input handshake and the result register.
//   A result register plus one skid entry sit on the output side, so a word
//   is still accepted while one result waits; in_stall rises only when both
//   entries are full, and falls as soon as the receiver takes a result.
//   The mode register (sixteen_bit_mode) is at address 0 of the APB-style
//   port; write it only while the block is idle.
//   Synchronous reset (rst_n low) clears the core state, empties both result
//   entries and sets sixteen_bit_mode to 1; the payload registers are not reset.
`timescale 1ns / 1ps

module i2c_gpio_expander_registers
  import gpx_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic      mode_r;
  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_word_t out_r, skid_r, res;
  logic      in_fire, out_fire, cfg_wr;
  logic      reg_idx;

  assign reg_idx = paddr[CFG_AW-1];
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready & (reg_idx == CFG_IDX_MODE);
  assign prdata  = (reg_idx == CFG_IDX_MODE) ? {31'b0, mode_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else if (cfg_wr) begin
      mode_r <= pwdata[0];
    end
  end

  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_fire  = out_valid_r & ~out_stall;

  gpx_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .fire             (in_fire),
    .item             (in_data),
    .sixteen_bit_mode (mode_r),
    .res              (res)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_fire) begin
      out_valid_nxt  = skid_valid_r | in_fire;
      skid_valid_nxt = 1'b0;
    end else if (in_fire) begin
      if (out_valid_r) skid_valid_nxt = 1'b1;
      else             out_valid_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload: older word always drains from the skid entry first
  always_ff @(posedge clk) begin
    if (out_fire) begin
      if (skid_valid_r)  out_r <= skid_r;
      else if (in_fire)  out_r <= res;
    end else if (in_fire && !out_valid_r) begin
      out_r <= res;
    end
    if (in_fire && out_valid_r && !out_fire) skid_r <= res;
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full while result register empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid entry filled without a stalled result");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !skid_valid_r && !in_fire |=> !out_valid_r)
    else $error("result register not emptied after handoff");

  a_ro_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == ST_RO |-> out_r.read_data == 8'h00)
    else $error("read-only error word carries read data");

  a_unsup_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == ST_UNSUP |->
      (out_r.read_data == 8'h00 || out_r.read_data == 8'hFF))
    else $error("unsupported register word has bad read data");

endmodule

[sv/gpx_core.sv]
// Register file and command decode of the GPIO expander.
// Updates state for each accepted word and forms its result word.
// Depends on gpx_pkg.
`timescale 1ns / 1ps

module gpx_core
  import gpx_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_word_t  item,
  input  logic      sixteen_bit_mode,
  output out_word_t res
);

  logic [7:0]  command_r, command_nxt;
  logic        expect_cmd_r, expect_cmd_nxt;
  logic [15:0] latch_r, latch_nxt;
  logic [15:0] polarity_r, polarity_nxt;
  logic [15:0] direction_r, direction_nxt;
  logic [15:0] input_r, input_nxt;
  logic [15:0] driven_r, driven_nxt;

  logic [7:0]  reg_sel;
  logic        lane_hi;
  logic [15:0] mask;
  logic [15:0] src;
  logic [7:0]  rd;
  logic [1:0]  status;

  function automatic logic [15:0] put_lane(input logic [15:0] r, input logic hi,
                                           input logic [7:0] b);
    return hi ? {b, r[7:0]} : {r[15:8], b};
  endfunction

  always_comb begin
    mask    = active_mask(sixteen_bit_mode);
    reg_sel = sixteen_bit_mode ? {1'b0, command_r[7:1]} : command_r;
    lane_hi = sixteen_bit_mode & command_r[0];

    command_nxt    = command_r;
    expect_cmd_nxt = expect_cmd_r;
    latch_nxt      = latch_r;
    polarity_nxt   = polarity_r;
    direction_nxt  = direction_r;
    input_nxt      = input_r;
    rd             = 8'h00;
    status         = ST_OK;
    src            = 16'hFFFF;

    case (item.kind)
      KIND_START: begin
        expect_cmd_nxt = 1'b1;
      end
      KIND_WRITE: begin
        if (expect_cmd_r) begin
          command_nxt    = item.data_byte;
          expect_cmd_nxt = 1'b0;
        end else begin
          case (reg_sel)
            REG_INPUT:     status = ST_RO;
            REG_OUTPUT:    latch_nxt = put_lane(latch_r, lane_hi, item.data_byte);
            REG_POLARITY:  polarity_nxt = put_lane(polarity_r, lane_hi, item.data_byte);
            REG_DIRECTION: direction_nxt = put_lane(direction_r, lane_hi, item.data_byte);
            default:       status = ST_UNSUP;
          endcase
        end
      end
      KIND_READ: begin
        case (reg_sel)
          REG_INPUT:     src = input_r;
          REG_OUTPUT:    src = latch_r;
          REG_POLARITY:  src = polarity_r;
          REG_DIRECTION: src = direction_r;
          default:       status = ST_UNSUP;
        endcase
        // unknown register reads all ones, lane does not matter
        rd = lane_hi ? src[15:8] : src[7:0];
      end
      KIND_PINS: begin
        input_nxt = item.pin_levels & mask;
      end
      default: begin
        // other bus events: no change
      end
    endcase

    // output pins follow the latch, input pins hold their last level
    driven_nxt = ((driven_r & direction_nxt) | (latch_nxt & ~direction_nxt)) & mask;

    res.read_data   = rd;
    res.pin_outputs = driven_nxt;
    res.status      = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      command_r    <= '0;
      expect_cmd_r <= 1'b0;
      latch_r      <= '0;
      polarity_r   <= '0;
      direction_r  <= '0;
      input_r      <= '0;
      driven_r     <= '0;
    end else if (fire) begin
      command_r    <= command_nxt;
      expect_cmd_r <= expect_cmd_nxt;
      latch_r      <= latch_nxt;
      polarity_r   <= polarity_nxt;
      direction_r  <= direction_nxt;
      input_r      <= input_nxt;
      driven_r     <= driven_nxt;
    end
  end

endmodule

[dv/tb_i2c_gpio_expander_registers.sv]
// Self-checking testbench for i2c_gpio_expander_registers: directed register
// traffic, random bus sequences and back-pressure, checked against a local predictor.
// Depends on gpx_pkg and the i2c_gpio_expander_registers RTL.
`timescale 1ns / 1ps

module tb_i2c_gpio_expander_registers;
  import gpx_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_SLACK = 4;
  localparam logic [2:0]  KIND_SPARE_LO = KIND_PINS + 3'd1;  // kinds above PINS act as OTHER

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_word_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_word_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // predictor state
  logic        mode16 = 1'b1;
  logic [7:0]  cmd_byte = '0;
  logic        want_cmd = 1'b0;
  logic [15:0] out_latch = '0;
  logic [15:0] pol_bits = '0;
  logic [15:0] dir_bits = '0;
  logic [15:0] in_levels = '0;
  logic [15:0] drive_levels = '0;

  out_word_t   pending_results[$];
  int unsigned failures = 0;
  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned mode_writes = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_len = 0;
  int unsigned hold_token = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  i2c_gpio_expander_registers DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  function automatic logic [15:0] put_byte(logic [15:0] old, int unsigned lane,
                                           logic [7:0] value);
    logic [15:0] lane_mask;
    lane_mask = 16'h00FF << lane;
    return (old & ~lane_mask) | (16'(value) << lane);
  endfunction

  function automatic out_word_t predict_expander_result(in_word_t w);
    logic [15:0] pin_mask;
    logic [7:0]  sel;
    logic [15:0] src;
    int unsigned lane;
    out_word_t   r;
    pin_mask = mode16 ? FULL_MASK : LOW_MASK;
    sel      = mode16 ? {1'b0, cmd_byte[7:1]} : cmd_byte;
    lane     = (mode16 && cmd_byte[0]) ? 8 : 0;
    r        = '0;
    r.status = ST_OK;
    case (w.kind)
      KIND_START: want_cmd = 1'b1;
      KIND_WRITE: begin
        if (want_cmd) begin
          cmd_byte = w.data_byte;
          want_cmd = 1'b0;
        end else begin
          case (sel)
            REG_INPUT:     r.status = ST_RO;
            REG_OUTPUT:    out_latch = put_byte(out_latch, lane, w.data_byte);
            REG_POLARITY:  pol_bits = put_byte(pol_bits, lane, w.data_byte);
            REG_DIRECTION: dir_bits = put_byte(dir_bits, lane, w.data_byte);
            default:       r.status = ST_UNSUP;
          endcase
        end
      end
      KIND_READ: begin
        case (sel)
          REG_INPUT:     src = in_levels;
          REG_OUTPUT:    src = out_latch;
          REG_POLARITY:  src = pol_bits;
          REG_DIRECTION: src = dir_bits;
          default: begin
            src      = 16'hFFFF;
            lane     = 0;
            r.status = ST_UNSUP;
          end
        endcase
        r.read_data = 8'(src >> lane);
      end
      KIND_PINS: in_levels = w.pin_levels & pin_mask;
      default: ;
    endcase
    // input pins hold their last driven level, output pins follow the latch
    drive_levels  = ((drive_levels & dir_bits) | (out_latch & ~dir_bits)) & pin_mask;
    r.pin_outputs = drive_levels;
    return r;
  endfunction

  // receiver stall: random, or a long hold-off when a new token is posted
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= hold_len;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %h", out_data);
        failures++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_data.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_data.read_data);
          failures++;
        end
        if (out_data.pin_outputs !== want.pin_outputs) begin
          $error("pin_outputs: expected %h, got %h", want.pin_outputs,
                 out_data.pin_outputs);
          failures++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("i2c_gpio_expander_registers test failed");
      $finish;
    end
  end

  task automatic send_word(in_word_t w);
    // each cycle the sender idles with the given chance
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_expander_result(w));
    words_sent++;
  endtask

  task automatic send_item(logic [2:0] kind, logic [7:0] data_byte, logic [15:0] pins);
    in_word_t w;
    w.kind       = kind;
    w.data_byte  = data_byte;
    w.pin_levels = pins;
    send_word(w);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // APB write of the mode register, then read it back
  task automatic write_mode(logic value);
    logic [31:0] rd;
    paddr   <= CFG_AW'(4 * CFG_IDX_MODE);
    pwdata  <= 32'(value);
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mode16 = value;
    mode_writes++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (rd[0] !== value) begin
      $error("sixteen_bit_mode readback: expected %0d, got %0d", value, rd[0]);
      failures++;
    end
  endtask

  task automatic test_wide_mode_registers();
    write_mode(1'b1);
    send_item(KIND_START, 8'h00, 16'h0000);
    send_item(KIND_WRITE, 8'h02, 16'h0000);   // output latch, low lane
    send_item(KIND_WRITE, 8'hA5, 16'h0000);
    send_item(KIND_READ,  8'h00, 16'h0000);
    send_item(KIND_START, 8'h00, 16'h0000);
    send_item(KIND_WRITE, 8'h03, 16'h0000);   // output latch, high lane
    send_item(KIND_WRITE, 8'hFF, 16'h0000);
    send_item(KIND_READ,  8'h00, 16'h0000);
    send_item(KIND_START, 8'h00, 16'h0000);
    send_item(KIND_WRITE, 8'h06, 16'h0000);   // direction, low lane
    send_item(KIND_WRITE, 8'hF0, 16'h0000);
    send_item(KIND_PINS,  8'h00, 16'hFFFF);
    send_item(KIND_START, 8'h00, 16'h0000);
    send_item(KIND_WRITE, 8'h00, 16'h0000);   // input register
    send_item(KIND_READ,  8'h00, 16'h0000);
    send_item(KIND_WRITE, 8'h12, 16'h0000);   // read-only write
    send_item(KIND_START, 8'h00, 16'h0000);
    send_item(KIND_WRITE, 8'hFE, 16'h0000);   // unknown register
    send_item(KIND_READ,  8'h00, 16'h0000);
    send_item(KIND_WRITE, 8'h33, 16'h0000);
    send_item(3'd7,       8'hFF, 16'hFFFF);
    send_item(KIND_PINS,  8'h00, 16'h0000);
    wait_results_drained();
  endtask

  task automatic test_narrow_mode_registers();
    write_mode(1'b0);
    send_item(KIND_START, 8'h00, 16'h0000);
    send_item(KIND_WRITE, 8'h01, 16'h0000);   // whole byte selects the register
    send_item(KIND_WRITE, 8'hC3, 16'h0000);
    send_item(KIND_READ,  8'h00, 16'h0000);
    send_item(KIND_START, 8'h00, 16'h0000);
    send_item(KIND_WRITE, 8'h02, 16'h0000);
    send_item(KIND_READ,  8'h00, 16'h0000);
    send_item(KIND_START, 8'h00, 16'h0000);
    send_item(KIND_WRITE, 8'h80, 16'h0000);
    send_item(KIND_READ,  8'h00, 16'h0000);
    wait_results_drained();
    write_mode(1'b1);
  endtask

  task automatic test_random_traffic(int unsigned target);
    int unsigned done_cnt;
    int unsigned choice;
    logic [7:0]  cmd;
    done_cnt = 0;
    while (done_cnt < target) begin
      choice = $urandom_range(0, 99);
      if (choice < 70) begin
        if ($urandom_range(0, 7) == 0) cmd = 8'($urandom);
        else if (mode16) cmd = 8'(($urandom_range(0, 3) << 1) | $urandom_range(0, 1));
        else cmd = 8'($urandom_range(0, 3));
        send_item(KIND_START, 8'($urandom), 16'($urandom));
        send_item(KIND_WRITE, cmd, 16'($urandom));
        done_cnt += 2;
        repeat ($urandom_range(1, 4)) begin
          send_item($urandom_range(0, 1) ? KIND_WRITE : KIND_READ, 8'($urandom),
                    16'($urandom));
          done_cnt++;
        end
      end else if (choice < 85) begin
        send_item(KIND_PINS, 8'($urandom), 16'($urandom));
        done_cnt++;
      end else if (choice < 93) begin
        // stray access or a start with no command byte after it
        case ($urandom_range(0, 2))
          0:       send_item(KIND_READ, 8'($urandom), 16'($urandom));
          1:       send_item(KIND_WRITE, 8'($urandom), 16'($urandom));
          default: send_item(KIND_START, 8'($urandom), 16'($urandom));
        endcase
        done_cnt++;
      end else if ($urandom_range(0, 1)) begin
        send_item(KIND_OTHER, 8'($urandom), 16'($urandom));
        done_cnt++;
      end else begin
        send_item(3'($urandom_range(KIND_SPARE_LO, 7)), 8'($urandom), 16'($urandom));
        done_cnt++;
      end
    end
    wait_results_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len      = 150;
    hold_token    = hold_token + 1;
    test_random_traffic(30);
    // burst, full pause until empty, then another burst
    test_random_traffic(12);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_wide_mode_registers();
    test_narrow_mode_registers();

    send_idle_pct = 32;
    recv_idle_pct = 66;
    test_random_traffic(120);

    write_mode(1'b0);
    send_idle_pct = 66;
    recv_idle_pct = 32;
    test_random_traffic(110);

    write_mode(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(110);

    test_backpressure();
    wait_results_drained();

    $display("Sent %0d words, checked %0d results, mode register written %0d times.",
             words_sent, results_checked, mode_writes);
    $display("Covered both pin widths, all registers and lanes, bad commands and hold-off.");
    if (failures == 0) begin
      $display("i2c_gpio_expander_registers test passed");
    end else begin
      $display("i2c_gpio_expander_registers test failed");
    end
    $finish;
  end

endmodule
